/* rtl/mtwg_pkg.sv */
// shared types, constants and functions for the mt19937 word generator
`timescale 1ns / 1ps
package mtwg_pkg;

    localparam int unsigned WORDS      = 624;
    localparam int unsigned SHIFT      = 397;
    localparam int unsigned ADDR_W     = 10;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [31:0] TWIST_XOR  = 32'h9908b0df;
    localparam logic [31:0] HIGH_BIT   = 32'h80000000;
    localparam logic [31:0] LOW_BITS   = 32'h7fffffff;
    localparam logic [31:0] TEMPER_B   = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_C   = 32'hefc60000;
    localparam logic [31:0] INIT_MULT  = 32'd1812433253;
    localparam logic [31:0] MIX1_MULT  = 32'd1664525;
    localparam logic [31:0] MIX2_MULT  = 32'd1566083941;
    localparam logic [31:0] INIT_SEED  = 32'd19650218;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT  = 2'd2;

    // classified operation handed from front to back
    typedef enum logic [1:0] {
        OP_DRAW   = 2'd0,
        OP_ZERO   = 2'd1,
        OP_RESEED = 2'd2
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [5:0] shift;
    } job_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FILL_RD,
        ST_FILL_MUL,
        ST_FILL_WR,
        ST_MIX_RD,
        ST_MIX_WAIT,
        ST_MIX_MUL,
        ST_MIX_WR,
        ST_WRAP_RD,
        ST_WRAP_WAIT,
        ST_WRAP_WR,
        ST_TOP_WR,
        ST_TW_RD0,
        ST_TW_RD1,
        ST_TW_RD2,
        ST_TW_WAIT,
        ST_TW_WR,
        ST_DRAW_RD,
        ST_DRAW_WAIT,
        ST_TEMPER,
        ST_OUT
    } state_t;

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic logic [31:0] mix_word(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] far_word);
        logic [31:0] y;
        logic [31:0] v;
        y = (a & HIGH_BIT) | (b & LOW_BITS);
        v = far_word ^ (y >> 1);
        if (y[0])
        begin
            v = v ^ TWIST_XOR;
        end
        return v;
    endfunction

endpackage

/* rtl/mtwg_ram.sv */
// generic single-port ram with registered read
`timescale 1ns / 1ps
module mtwg_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 624
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write or read one entry a cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

/* rtl/mtwg_front.sv */
// front end: accepts beats, classifies them and queues jobs
`timescale 1ns / 1ps
module mtwg_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          valid,
    output logic          ready,
    input  logic          cmd,
    input  logic [5:0]    bit_count,
    output logic          job_valid,
    input  logic          job_take,
    output mtwg_pkg::job_t job
);
    import mtwg_pkg::*;

    job_t       q_reg [QUEUE_DEPTH];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, rd_next;
    logic       wr_reg, wr_next;
    job_t       in_job;
    logic       push, pop;

    // classify the incoming beat
    always_comb
    begin
        in_job.shift = 6'd0;
        if (cmd)
        begin
            in_job.op = OP_RESEED;
        end
        else if (bit_count == 6'd0)
        begin
            in_job.op = OP_ZERO;
        end
        else
        begin
            in_job.op = OP_DRAW;
            if (bit_count > 6'd32)
            begin
                in_job.shift = 6'd0;
            end
            else
            begin
                in_job.shift = 6'd32 - bit_count;
            end
        end
    end

    assign ready     = (cnt_reg != 2'(QUEUE_DEPTH));
    assign push      = valid && ready;
    assign job_valid = (cnt_reg != 2'd0);
    assign pop       = job_valid && job_take;
    assign job       = q_reg[rd_reg];

    // queue pointers
    always_comb
    begin
        cnt_next = cnt_reg;
        rd_next  = rd_reg;
        wr_next  = wr_reg;
        if (push)
        begin
            wr_next = ~wr_reg;
        end
        if (pop)
        begin
            rd_next = ~rd_reg;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= in_job;
        end
    end
endmodule

/* rtl/mtwg_back.sv */
// back end: sequencer for seeding, twisting and drawing over the state ram
`timescale 1ns / 1ps
module mtwg_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    output logic           job_take,
    input  mtwg_pkg::job_t job,
    input  logic [31:0]    key_first,
    input  logic [31:0]    key_second,
    input  logic           key_two,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [31:0]    random_bits
);
    import mtwg_pkg::*;

    localparam logic [ADDR_W-1:0] LAST  = ADDR_W'(WORDS - 1);
    localparam logic [ADDR_W-1:0] WRDS  = ADDR_W'(WORDS);
    localparam logic [ADDR_W-1:0] FAR   = ADDR_W'(SHIFT);

    state_t            st_reg, st_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [ADDR_W-1:0] i_reg, i_next;
    logic [ADDR_W-1:0] k_reg, k_next;
    logic              j_reg, j_next;
    logic              pass2_reg, pass2_next;
    logic [5:0]        shift_reg, shift_next;
    logic [31:0]       a_reg, a_next;
    logic [31:0]       b_reg, b_next;
    logic [31:0]       c_reg, c_next;
    logic [31:0]       prod_reg, prod_next;
    logic [31:0]       out_reg, out_next;
    logic              ov_reg, ov_next;

    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       wdata;
    logic [31:0]       rdata;
    logic [31:0]       pmix;
    logic [ADDR_W-1:0] nxt_addr;
    logic [ADDR_W-1:0] far_addr;
    logic [ADDR_W:0]   far_sum;

    mtwg_ram #(.WIDTH(32), .DEPTH(WORDS)) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    assign pmix     = a_reg ^ (a_reg >> 30);
    assign nxt_addr = (i_reg == LAST) ? '0 : i_reg + 1'b1;
    assign far_sum  = {1'b0, i_reg} + {1'b0, FAR};
    assign far_addr = (far_sum >= {1'b0, WRDS}) ? ADDR_W'(far_sum - {1'b0, WRDS})
                                                : far_sum[ADDR_W-1:0];
    assign out_valid   = ov_reg;
    assign random_bits = out_reg;

    // next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (job_valid && !ov_reg)
                begin
                    case (job.op)
                        OP_RESEED: st_next = ST_FILL_WR;
                        OP_ZERO:   st_next = ST_IDLE;
                        default:   st_next = (pos_reg >= WRDS) ? ST_TW_RD0 : ST_DRAW_RD;
                    endcase
                end
            end
            ST_FILL_RD:   st_next = ST_FILL_MUL;
            ST_FILL_MUL:  st_next = ST_FILL_WR;
            ST_FILL_WR:   st_next = (i_reg == LAST) ? ST_MIX_RD : ST_FILL_RD;
            ST_MIX_RD:    st_next = ST_MIX_WAIT;
            ST_MIX_WAIT:  st_next = ST_MIX_MUL;
            ST_MIX_MUL:   st_next = ST_MIX_WR;
            ST_MIX_WR:    st_next = (i_reg == LAST) ? ST_WRAP_RD
                                  : (k_reg == 10'd1) ? (pass2_reg ? ST_TOP_WR : ST_MIX_RD)
                                  : ST_MIX_RD;
            ST_WRAP_RD:   st_next = ST_WRAP_WAIT;
            ST_WRAP_WAIT: st_next = ST_WRAP_WR;
            ST_WRAP_WR:   st_next = (k_reg == '0) ? (pass2_reg ? ST_TOP_WR : ST_MIX_RD)
                                  : ST_MIX_RD;
            ST_TOP_WR:    st_next = ST_IDLE;
            ST_TW_RD0:    st_next = ST_TW_RD1;
            ST_TW_RD1:    st_next = ST_TW_RD2;
            ST_TW_RD2:    st_next = ST_TW_WAIT;
            ST_TW_WAIT:   st_next = ST_TW_WR;
            ST_TW_WR:     st_next = (i_reg == LAST) ? ST_DRAW_RD : ST_TW_RD0;
            ST_DRAW_RD:   st_next = ST_DRAW_WAIT;
            ST_DRAW_WAIT: st_next = ST_TEMPER;
            ST_TEMPER:    st_next = ST_OUT;
            ST_OUT:       st_next = ST_IDLE;
            default:      st_next = ST_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb
    begin
        pos_next   = pos_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        pass2_next = pass2_reg;
        shift_next = shift_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        prod_next  = prod_reg;
        out_next   = out_reg;
        ov_next    = ov_reg && !out_ready;
        job_take   = 1'b0;
        we         = 1'b0;
        addr       = i_reg;
        wdata      = a_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (job_valid && !ov_reg)
                begin
                    job_take   = 1'b1;
                    shift_next = job.shift;
                    i_next     = '0;
                    case (job.op)
                        OP_RESEED:
                        begin
                            a_next = INIT_SEED;
                        end
                        OP_ZERO:
                        begin
                            out_next = '0;
                            ov_next  = 1'b1;
                        end
                        default:
                        begin
                            i_next = (pos_reg >= WRDS) ? '0 : pos_reg;
                        end
                    endcase
                end
            end
            // fill: a holds previous word
            ST_FILL_RD:
            begin
                prod_next = pmix * INIT_MULT;
            end
            ST_FILL_MUL:
            begin
                a_next = prod_reg + 32'(i_reg);
            end
            ST_FILL_WR:
            begin
                we    = 1'b1;
                wdata = a_reg;
                if (i_reg == LAST)
                begin
                    // the first mixing step works from word 0, the seed
                    a_next     = INIT_SEED;
                    i_next     = 10'd1;
                    k_next     = WRDS;
                    j_next     = 1'b0;
                    pass2_next = 1'b0;
                    pos_next   = WRDS;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            // mixing: a holds word i-1
            ST_MIX_RD:
            begin
                addr      = i_reg;
                prod_next = pmix * (pass2_reg ? MIX2_MULT : MIX1_MULT);
            end
            ST_MIX_WAIT:
            begin
                b_next = rdata;
            end
            ST_MIX_MUL:
            begin
                if (pass2_reg)
                begin
                    a_next = (b_reg ^ prod_reg) - 32'(i_reg);
                end
                else
                begin
                    a_next = (b_reg ^ prod_reg) + (j_reg ? key_second : key_first)
                             + 32'(j_reg);
                end
            end
            ST_MIX_WR:
            begin
                we     = 1'b1;
                k_next = k_reg - 1'b1;
                j_next = key_two ? ~j_reg : 1'b0;
                if (i_reg == LAST)
                begin
                    i_next = '0;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    if (k_reg == 10'd1 && !pass2_reg)
                    begin
                        k_next     = LAST;
                        pass2_next = 1'b1;
                    end
                end
            end
            // copy top word into word 0; a still holds it
            ST_WRAP_RD:
            begin
                addr = '0;
            end
            ST_WRAP_WAIT:
            begin
                addr = '0;
            end
            ST_WRAP_WR:
            begin
                we     = 1'b1;
                addr   = '0;
                i_next = 10'd1;
                if (k_reg == '0 && !pass2_reg)
                begin
                    k_next     = LAST;
                    pass2_next = 1'b1;
                end
            end
            ST_TOP_WR:
            begin
                we    = 1'b1;
                addr  = '0;
                wdata = HIGH_BIT;
            end
            // twist: read i, i+1, far; write i
            ST_TW_RD0:
            begin
                addr = i_reg;
            end
            ST_TW_RD1:
            begin
                addr   = nxt_addr;
                a_next = rdata;
            end
            ST_TW_RD2:
            begin
                addr   = far_addr;
                b_next = rdata;
            end
            ST_TW_WAIT:
            begin
                c_next = rdata;
            end
            ST_TW_WR:
            begin
                we     = 1'b1;
                addr   = i_reg;
                wdata  = mix_word(a_reg, b_reg, c_reg);
                i_next = (i_reg == LAST) ? '0 : i_reg + 1'b1;
            end
            ST_DRAW_RD:
            begin
                addr = i_reg;
            end
            ST_DRAW_WAIT:
            begin
                a_next = rdata;
            end
            ST_TEMPER:
            begin
                a_next   = temper(a_reg);
                pos_next = i_reg + 1'b1;
            end
            ST_OUT:
            begin
                out_next = a_reg >> shift_reg;
                ov_next  = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            pos_reg   <= WRDS;
            ov_reg    <= 1'b0;
            pass2_reg <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            pos_reg   <= pos_next;
            ov_reg    <= ov_next;
            pass2_reg <= pass2_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        k_reg     <= k_next;
        j_reg     <= j_next;
        shift_reg <= shift_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
        prod_reg  <= prod_next;
        out_reg   <= out_next;
    end
endmodule

/* rtl/mt19937_word_generator_top.sv */
// top level of the mt19937 word generator
`timescale 1ns / 1ps
// usage
// in channel: in_valid/in_ready carry cmd (0 draw, 1 reseed) and bit_count.
// out channel: out_valid/out_ready carry random_bits, one beat per draw.
// config: cfg_we writes key_first_word (0), key_second_word (1),
// key_word_count (2) from cfg_data; write only while idle.
// a front queue of two jobs takes beats while the back end is busy.
// the back end walks a single-port 624-word ram, one access per cycle:
// a draw from a fresh position reads the word, waits for the ram, tempers
// it and shifts it into the output register; a draw that needs a twist
// first rewrites every word from words i, i+1 and i+397 (mod 624).
// a reseed fills every word, then runs the two mixing passes, and gives
// no beat. the back end takes a new job only once it is back in idle.
// a bit_count of zero returns a zero beat without using a word.
// the result sits in an output register; while out_ready is low the back
// end takes no new job and the front queue keeps taking beats until full.
// reset clears the queue and sets the read position to 624; the state ram
// is undefined until the first reseed, and draws must follow a reseed.
module mt19937_word_generator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [5:0]  bit_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] random_bits,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import mtwg_pkg::*;

    logic [31:0] key_first_reg;
    logic [31:0] key_second_reg;
    logic [1:0]  key_count_reg;
    logic        job_valid;
    logic        job_take;
    job_t        job;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_first_reg  <= '0;
            key_second_reg <= '0;
            key_count_reg  <= 2'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_FIRST:  key_first_reg  <= cfg_data;
                REG_KEY_SECOND: key_second_reg <= cfg_data;
                REG_KEY_COUNT:  key_count_reg  <= cfg_data[1:0];
                default:        ;
            endcase
        end
    end

    mtwg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (in_valid),
        .ready     (in_ready),
        .cmd       (cmd),
        .bit_count (bit_count),
        .job_valid (job_valid),
        .job_take  (job_take),
        .job       (job)
    );

    mtwg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job_valid),
        .job_take    (job_take),
        .job         (job),
        .key_first   (key_first_reg),
        .key_second  (key_second_reg),
        .key_two     (key_count_reg[1]),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .random_bits (random_bits)
    );

    // a job is taken only when one is queued
    assert property (@(posedge clk) disable iff (!rst_n) job_take |-> job_valid)
        else $error("job taken from empty queue");

    // a stalled result beat holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(random_bits))
        else $error("result beat changed while stalled");

    // no job leaves the queue while a result is waiting
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !job_take)
        else $error("job taken with result pending");
endmodule

/* tb/tb.sv */
// self-checking testbench for the mt19937 word generator
`timescale 1ns / 1ps
module tb;
    import mtwg_pkg::*;

    localparam int STATE_WORDS = 624;
    localparam int HANG_LIMIT  = 60000;
    localparam int SETTLE_CYC  = 16000;

    // reference state of the generator and the queue of words still owed
    class mt_scoreboard;
        logic [31:0] state_words [STATE_WORDS];
        int          read_pos;
        logic [31:0] key_word [2];
        logic [1:0]  key_count;
        logic [31:0] owed_words [$];
        int          errors;
        int          draws;
        int          reseeds;
        int          checked;

        function new();
            foreach (state_words[n])
            begin
                state_words[n] = '0;
            end
            read_pos    = STATE_WORDS;
            key_word[0] = '0;
            key_word[1] = '0;
            key_count   = 2'd1;
        endfunction

        function void set_reg(input logic [1:0] idx, input logic [31:0] val);
            case (idx)
                REG_KEY_FIRST:  key_word[0] = val;
                REG_KEY_SECOND: key_word[1] = val;
                REG_KEY_COUNT:  key_count   = val[1:0];
                default: ;
            endcase
        endfunction

        // regenerate the whole store in place
        function void twist_store();
            logic [31:0] y;
            logic [31:0] v;
            for (int n = 0; n < STATE_WORDS; n++)
            begin
                y = (state_words[n] & 32'h80000000)
                    | (state_words[(n + 1) % STATE_WORDS] & 32'h7fffffff);
                v = state_words[(n + 397) % STATE_WORDS] ^ (y >> 1);
                if (y[0])
                begin
                    v = v ^ 32'h9908b0df;
                end
                state_words[n] = v;
            end
            read_pos = 0;
        endfunction

        // fixed seed fill, then two mixing passes over the key
        function void seed_store();
            logic [31:0] p;
            int          i;
            int          j;
            int          klen;
            klen = (key_count >= 2) ? 2 : 1;
            state_words[0] = 32'd19650218;
            for (int n = 1; n < STATE_WORDS; n++)
            begin
                p = state_words[n-1];
                state_words[n] = 32'd1812433253 * (p ^ (p >> 30)) + 32'(n);
            end
            i = 1;
            j = 0;
            for (int k = 0; k < STATE_WORDS; k++)
            begin
                p = state_words[i-1];
                state_words[i] = (state_words[i] ^ ((p ^ (p >> 30)) * 32'd1664525))
                                 + key_word[j & 1] + 32'(j);
                i++;
                j++;
                if (i >= STATE_WORDS)
                begin
                    state_words[0] = state_words[STATE_WORDS-1];
                    i = 1;
                end
                if (j >= klen)
                begin
                    j = 0;
                end
            end
            for (int k = 0; k < STATE_WORDS - 1; k++)
            begin
                p = state_words[i-1];
                state_words[i] = (state_words[i] ^ ((p ^ (p >> 30)) * 32'd1566083941))
                                 - 32'(i);
                i++;
                if (i >= STATE_WORDS)
                begin
                    state_words[0] = state_words[STATE_WORDS-1];
                    i = 1;
                end
            end
            state_words[0] = 32'h80000000;
            read_pos = STATE_WORDS;
        endfunction

        function logic [31:0] tempered_word();
            logic [31:0] y;
            if (read_pos >= STATE_WORDS)
            begin
                twist_store();
            end
            y = state_words[read_pos];
            read_pos++;
            y = y ^ (y >> 11);
            y = y ^ ((y << 7) & 32'h9d2c5680);
            y = y ^ ((y << 15) & 32'hefc60000);
            y = y ^ (y >> 18);
            return y;
        endfunction

        // accepted input beat
        function void note_input(input bit is_reseed, input logic [5:0] nbits);
            int b;
            if (is_reseed)
            begin
                reseeds++;
                seed_store();
                return;
            end
            draws++;
            if (nbits == 0)
            begin
                owed_words.push_back('0);
                return;
            end
            b = (nbits > 32) ? 32 : int'(nbits);
            owed_words.push_back(tempered_word() >> (32 - b));
        endfunction

        task report(input string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // accepted output beat
        task check_output(input logic [31:0] got);
            logic [31:0] want;
            if (owed_words.size() == 0)
            begin
                report($sformatf("unexpected random_bits %h", got));
                return;
            end
            want = owed_words.pop_front();
            checked++;
            if (got !== want)
            begin
                report($sformatf("random_bits %h, expected %h", got, want));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        cmd;
    logic [5:0]  bit_count;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] random_bits;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    mt_scoreboard sb;
    bit quiet;
    bit held;
    int n_out;
    int hang_cnt;

    mt19937_word_generator_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .bit_count  (bit_count),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .random_bits(random_bits),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // output beats go to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_output(random_bits);
            n_out++;
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            hang_cnt = 0;
        end
        else
        begin
            hang_cnt++;
            if (hang_cnt >= HANG_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles", HANG_LIMIT);
                $display("tb failed");
                $finish;
            end
        end
    end

    // receiver with random stalls and one long hold-off
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (n_out == 150 && !held)
            begin
                held      = 1'b1;
                out_ready = 1'b0;
                repeat (400) @(negedge clk);
            end
            else
            begin
                out_ready = quiet || ($urandom_range(99) >= 22);
            end
        end
    end

    task write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task send_beat(input bit is_reseed, input logic [5:0] nbits);
        if (!quiet && $urandom_range(99) < 22)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid  = 1'b1;
        cmd       = is_reseed;
        bit_count = nbits;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        sb.note_input(is_reseed, nbits);
        @(negedge clk);
    endtask

    // mostly legal widths, a few zero and oversize
    task send_random_draw();
        int r;
        r = $urandom_range(99);
        if (r < 5)
        begin
            send_beat(1'b0, 6'd0);
        end
        else if (r < 10)
        begin
            send_beat(1'b0, 6'($urandom_range(33, 63)));
        end
        else
        begin
            send_beat(1'b0, 6'($urandom_range(1, 32)));
        end
    endtask

    // drain results and let trailing reseeds finish before touching config
    task settle();
        in_valid = 1'b0;
        while (sb.owed_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYC) @(posedge clk);
        @(negedge clk);
    endtask

    task run_phase(input logic [31:0] k0, input logic [31:0] k1, input logic [1:0] kc,
                   input int nitems);
        write_reg(REG_KEY_FIRST, k0);
        write_reg(REG_KEY_SECOND, k1);
        write_reg(REG_KEY_COUNT, 32'(kc));
        send_beat(1'b1, 6'($urandom_range(63)));
        for (int n = 0; n < nitems; n++)
        begin
            if ($urandom_range(99) < 5)
            begin
                send_beat(1'b1, 6'($urandom_range(63)));
            end
            else
            begin
                send_random_draw();
            end
        end
        settle();
    endtask

    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        cmd       = 1'b0;
        bit_count = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        quiet     = 1'b0;
        held      = 1'b0;
        n_out     = 0;
        hang_cnt  = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: zero key, width extremes, zero and oversize widths, reseed again
        write_reg(REG_KEY_FIRST, 32'h0);
        write_reg(REG_KEY_SECOND, 32'h0);
        write_reg(REG_KEY_COUNT, 32'd1);
        send_beat(1'b1, 6'd0);
        send_beat(1'b0, 6'd1);
        send_beat(1'b0, 6'd32);
        send_beat(1'b0, 6'd0);
        send_beat(1'b0, 6'd33);
        send_beat(1'b0, 6'd63);
        send_beat(1'b0, 6'd31);
        send_beat(1'b0, 6'd16);
        send_beat(1'b0, 6'd2);
        send_beat(1'b0, 6'd32);
        send_beat(1'b1, 6'd63);
        send_beat(1'b0, 6'd32);
        send_beat(1'b0, 6'd0);
        send_beat(1'b0, 6'd1);
        send_beat(1'b0, 6'd48);
        send_beat(1'b0, 6'd32);
        settle();

        // long run with a no-idle stretch and the hold-off
        write_reg(REG_KEY_FIRST, $urandom);
        write_reg(REG_KEY_SECOND, $urandom);
        write_reg(REG_KEY_COUNT, 32'd2);
        send_beat(1'b1, 6'd5);
        for (int n = 0; n < 450; n++)
        begin
            quiet = (n >= 100 && n < 300);
            send_random_draw();
        end
        quiet = 1'b0;
        settle();

        // key extremes and out-of-range key counts
        run_phase(32'hffffffff, 32'hffffffff, 2'd2, 20);
        run_phase($urandom, $urandom, 2'd0, 20);
        run_phase($urandom, $urandom, 2'd3, 20);
        run_phase($urandom, $urandom, 2'd1, 20);

        repeat (100) @(posedge clk);
        $display("covered %0d draws and %0d reseeds, %0d results checked",
                 sb.draws, sb.reseeds, sb.checked);
        $display("key counts 0 to 3, zero and oversize widths, a receiver hold-off");
        if (sb.errors == 0 && sb.owed_words.size() == 0)
        begin
            $display("tb passed");
        end
        else
        begin
            $display("%0d mismatches, %0d results missing", sb.errors,
                     sb.owed_words.size());
            $display("tb failed");
        end
        $finish;
    end
endmodule
